// ----- src/stp_pkg.sv -----
// shared constants and types of the software timer pool
`timescale 1ns / 1ps

package stp_pkg;

  // pool size and the widths that follow from it
  localparam int TimerCount = 16;
  localparam int MaxResults = 16;
  localparam int IdxW       = (TimerCount > 1) ? $clog2(TimerCount) : 1;
  localparam int CntW       = $clog2(MaxResults + 1);

  // fixed field widths
  localparam int CmdW    = 2;
  localparam int ModeW   = 2;
  localparam int PeriodW = 31;
  localparam int IndexW  = 5;
  localparam int KindW   = 2;
  localparam int StatusW = 2;
  localparam int SlotW   = 5;
  localparam int CountW  = 32;

  // stream widths: tdata packed from the lowest bit, padded to bytes
  localparam int InDataW  = ((ModeW + PeriodW + IndexW + 7) / 8) * 8;
  localparam int OutDataW = ((StatusW + SlotW + 1 + 7) / 8) * 8;

  typedef enum logic [CmdW-1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    MODE_TIMER  = 2'd0,
    MODE_ONCE   = 2'd1,
    MODE_CYCLIC = 2'd2,
    MODE_BAD    = 2'd3
  } mode_e;

  typedef enum logic [KindW-1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_FIRE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_BAD_MODE  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_REPLY,
    S_WALK,
    S_FLUSH
  } state_e;

endpackage

// ----- src/software_timer_pool.sv -----
// software timer pool: slot allocation, stop and a per-tick walk over all slots
// stop goes straight to its reply, start first scans for a free slot
// tick: a walk over every slot, then a flush state, one slot per cycle unless a fire waits
// on a stalled output, through a single countdown adder; fires leave at most one per cycle
// throughput: one item at a time, the input is ready only while the sequencer idles
// reset: asynchronous active low, all slots free, sequencer idle, no result pending
`timescale 1ns / 1ps

module software_timer_pool
  import stp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input item
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // mode[1:0], period[32:2], timer_index[37:33]
  input  logic [CmdW-1:0]     s_axis_tuser,  // cmd
  // result item
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // status[1:0], slot[6:2], ended[7]
  output logic [KindW-1:0]    m_axis_tuser,  // kind
  output logic                m_axis_tlast   // last
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TimerCount - 1);

  // input field unpacking
  logic [ModeW-1:0]   in_mode;
  logic [PeriodW-1:0] in_period;
  logic [IndexW-1:0]  in_index;
  cmd_e               in_cmd;

  assign in_mode   = s_axis_tdata[ModeW-1:0];
  assign in_period = s_axis_tdata[ModeW+PeriodW-1:ModeW];
  assign in_index  = s_axis_tdata[ModeW+PeriodW+IndexW-1:ModeW+PeriodW];
  assign in_cmd    = cmd_e'(s_axis_tuser);

  // slot store
  logic [TimerCount-1:0] in_use_q;
  logic [ModeW-1:0]      slot_mode_q   [TimerCount];
  logic [PeriodW-1:0]    slot_period_q [TimerCount];
  logic [CountW-1:0]     slot_cnt_q    [TimerCount];

  // sequencer and item registers
  state_e             state_q, state_d;
  logic [IdxW-1:0]    idx_q;
  logic [ModeW-1:0]   mode_q;
  logic [PeriodW-1:0] period_q;
  kind_e              res_kind_q;
  status_e            res_status_q;
  logic [SlotW-1:0]   res_slot_q;

  // pending fire, held back until the next one shows whether it is the last
  logic               pend_valid_q;
  logic [SlotW-1:0]   pend_slot_q;
  logic               pend_ended_q;
  logic [CntW-1:0]    fire_cnt_q;

  // output register
  logic               out_valid_q;
  kind_e              out_kind_q;
  status_e            out_status_q;
  logic [SlotW-1:0]   out_slot_q;
  logic               out_ended_q;
  logic               out_last_q;

  // control signals
  logic              out_free;
  logic              out_load;
  logic              in_acc;
  logic              cur_use;
  logic [ModeW-1:0]  cur_mode;
  logic [CountW-1:0] cur_cnt;
  logic              cur_fire;
  logic              cur_report;
  logic              walk_go;
  logic              walk_last;
  logic              stop_ok;
  logic [CountW-1:0] addend;
  logic [CountW-1:0] cnt_next;

  // shared countdown unit: count - 1, plus the period on a cyclic reload
  always_comb begin
    cur_use  = in_use_q[idx_q];
    cur_mode = slot_mode_q[idx_q];
    cur_cnt  = slot_cnt_q[idx_q];
    // count - 1 is zero or negative
    cur_fire = (cur_cnt == '0) || (cur_cnt == CountW'(1)) ||
               (cur_cnt[CountW-1] && (cur_cnt != {1'b1, {(CountW-1){1'b0}}}));
    addend   = (cur_fire && (cur_mode == MODE_CYCLIC)) ? {1'b0, slot_period_q[idx_q]} : '0;
    cnt_next = cur_cnt + addend + {CountW{1'b1}};
  end

  // handshake and walk control
  always_comb begin
    out_free      = !out_valid_q || m_axis_tready;
    s_axis_tready = (state_q == S_IDLE);
    in_acc        = s_axis_tvalid && s_axis_tready;
    cur_report    = cur_use && cur_fire && (cur_mode != MODE_TIMER) &&
                    (fire_cnt_q < CntW'(MaxResults));
    walk_go       = (state_q == S_WALK) && !(cur_report && pend_valid_q && !out_free);
    walk_last     = (idx_q == LastIdx);
    stop_ok       = (32'(in_index) < TimerCount);
    out_load      = ((state_q == S_REPLY) && out_free) ||
                    (walk_go && cur_report && pend_valid_q) ||
                    ((state_q == S_FLUSH) && pend_valid_q && out_free);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_START: state_d = S_FIND;
            CMD_STOP:  state_d = S_REPLY;
            CMD_TICK:  state_d = S_WALK;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (!cur_use || walk_last) state_d = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) state_d = S_IDLE;
      end
      S_WALK: begin
        if (walk_go && walk_last) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_use_q     <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      fire_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          idx_q        <= '0;
          pend_valid_q <= 1'b0;
          fire_cnt_q   <= '0;
          if (in_acc && (in_cmd == CMD_STOP) && stop_ok) begin
            in_use_q[in_index[IdxW-1:0]] <= 1'b0;
          end
        end
        S_FIND: begin
          if (!cur_use) begin
            if (mode_q != MODE_BAD) in_use_q[idx_q] <= 1'b1;
          end else if (!walk_last) begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_WALK: begin
          if (walk_go) begin
            if (!walk_last) idx_q <= idx_q + IdxW'(1);
            if (cur_use && cur_fire && (cur_mode != MODE_CYCLIC)) in_use_q[idx_q] <= 1'b0;
            if (cur_report) begin
              pend_valid_q <= 1'b1;
              fire_cnt_q   <= fire_cnt_q + CntW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (pend_valid_q && out_free) begin
            pend_valid_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers and slot store
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_q   <= in_mode;
          period_q <= in_period;
          if (in_cmd == CMD_STOP) begin
            res_kind_q   <= KIND_STOP;
            res_status_q <= stop_ok ? ST_OK : ST_BAD_INDEX;
            res_slot_q   <= '0;
          end else begin
            res_kind_q   <= KIND_START;
          end
        end
      end
      S_FIND: begin
        if (!cur_use) begin
          if (mode_q == MODE_BAD) begin
            res_status_q <= ST_BAD_MODE;
            res_slot_q   <= '0;
          end else begin
            res_status_q         <= ST_OK;
            res_slot_q           <= SlotW'(idx_q);
            slot_mode_q[idx_q]   <= mode_q;
            slot_period_q[idx_q] <= period_q;
            slot_cnt_q[idx_q]    <= {1'b0, period_q};
          end
        end else if (walk_last) begin
          res_status_q <= ST_NO_SLOT;
          res_slot_q   <= '0;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_kind_q   <= res_kind_q;
          out_status_q <= res_status_q;
          out_slot_q   <= res_slot_q;
          out_ended_q  <= 1'b0;
          out_last_q   <= 1'b1;
        end
      end
      S_WALK: begin
        if (walk_go) begin
          if (cur_use) slot_cnt_q[idx_q] <= cnt_next;
          if (cur_report) begin
            pend_slot_q  <= SlotW'(idx_q);
            pend_ended_q <= (cur_mode == MODE_ONCE);
            if (pend_valid_q) begin
              out_kind_q   <= KIND_FIRE;
              out_status_q <= ST_OK;
              out_slot_q   <= pend_slot_q;
              out_ended_q  <= pend_ended_q;
              out_last_q   <= 1'b0;
            end
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_kind_q   <= KIND_FIRE;
          out_status_q <= ST_OK;
          out_slot_q   <= pend_slot_q;
          out_ended_q  <= pend_ended_q;
          out_last_q   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result port
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OutDataW'({out_ended_q, out_slot_q, out_status_q});

endmodule

// ----- src/stp_checker.sv -----
// port-level checks of the software timer pool, bound to the top level
`timescale 1ns / 1ps

module stp_checker
  import stp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [CmdW-1:0]     s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [KindW-1:0]    m_axis_tuser,
  input logic                m_axis_tlast
);

  // a result waits until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // any real command leaves the sequencer busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_NONE) |=> !s_axis_tready)
    else $error("input taken again while a command is in work");

  // start and stop replies are single items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == KIND_START) || (m_axis_tuser == KIND_STOP))
    |-> m_axis_tlast)
    else $error("reply not marked last");

  // fires report ok and a slot in range, ended only on fires
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FIRE)
    |-> (m_axis_tdata[StatusW-1:0] == ST_OK) &&
        (32'(m_axis_tdata[StatusW+SlotW-1:StatusW]) < TimerCount))
    else $error("fire with bad status or slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != KIND_FIRE) |-> !m_axis_tdata[StatusW+SlotW])
    else $error("ended set outside a fire");

endmodule

bind software_timer_pool stp_checker u_stp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
